@@ rtl/two_sum_pair_finder_macros.svh @@
`ifndef TWO_SUM_PAIR_FINDER_MACROS_SVH
`define TWO_SUM_PAIR_FINDER_MACROS_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/tsp_pkg.sv @@
package tsp_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int TARGET_BITS = 33;
	localparam int POS_BITS    = 11;
	localparam int APB_DW      = 64;
	localparam int APB_AW      = 1;

	localparam logic [APB_AW-1:0] REG_TARGET = 1'b0;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last_item;
	} item_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] first_position;
		logic [POS_BITS-1:0] second_position;
	} result_t;

	// per-request control passed from front to back
	typedef struct packed {
		logic last;
		logic keep;
	} ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RDI,
		ST_GETI,
		ST_RDJ,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

@@ rtl/two_sum_pair_finder.sv @@
// channel  | direction | handshake         | payload
// config   | in        | psel/penable/pwrite| paddr, pwdata, prdata (target_sum at 0x0)
// item     | in        | push / full       | item (value, last_item)
// result   | out       | pop / empty       | result (found, first/second_position)
//
// Loading takes one request per cycle unless full; a four-entry queue sits between front and back.
// A last request runs the search over the value memory: per position i the states RDI and GETI,
// then per compared partner j the states RDJ and CMP, until a match or the end of the list.
// Reset clears control only; the value memory is not cleared (only written entries are read).
// full rises while the back end searches and the queue fills; a waiting result stalls the next search.
module two_sum_pair_finder #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsp_pkg::APB_AW-1:0]     paddr,
	input  logic [tsp_pkg::APB_DW-1:0]     pwdata,
	output logic [tsp_pkg::APB_DW-1:0]     prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  tsp_pkg::item_t                 item,
	output logic                           empty,
	input  logic                           pop,
	output tsp_pkg::result_t               result
);
	localparam int CW = $clog2(MAX_ITEMS+1);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int VB = tsp_pkg::VALUE_BITS;
	localparam int QW = 2 + VB + AW + CW;

	logic [tsp_pkg::TARGET_BITS-1:0] target_q;

	logic                f_push;
	tsp_pkg::ctl_t       f_ctl, b_ctl;
	logic [VB-1:0]       f_value, b_value;
	logic [AW-1:0]       f_pos, b_pos;
	logic [CW-1:0]       f_count, b_count;
	logic                q_full, q_empty, q_pop;
	logic [QW-1:0]       q_rdata;

	assign pready = 1'b1;
	assign prdata = tsp_pkg::APB_DW'(target_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && paddr == tsp_pkg::REG_TARGET) begin
			target_q <= pwdata[tsp_pkg::TARGET_BITS-1:0];
		end
	end

	assign full = q_full;

	tsp_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_full  (q_full),
		.item    (item),
		.q_push  (f_push),
		.q_ctl   (f_ctl),
		.q_value (f_value),
		.q_pos   (f_pos),
		.q_count (f_count)
	);

	tsp_fifo #(.W(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  ({f_ctl, f_value, f_pos, f_count}),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_ctl, b_value, b_pos, b_count} = q_rdata;

	tsp_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (target_q),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_ctl   (b_ctl),
		.q_value (b_value),
		.q_pos   (b_pos),
		.q_count (b_count),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

@@ rtl/tsp_front.sv @@
module tsp_front #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            q_full,
	input  tsp_pkg::item_t                  item,
	output logic                            q_push,
	output tsp_pkg::ctl_t                   q_ctl,
	output logic [tsp_pkg::VALUE_BITS-1:0]  q_value,
	output logic [$clog2(MAX_ITEMS)-1:0]    q_pos,
	output logic [$clog2(MAX_ITEMS+1)-1:0]  q_count
);
	localparam int CW = $clog2(MAX_ITEMS+1);
	localparam int AW = $clog2(MAX_ITEMS);

	logic [CW-1:0] cnt_q;
	logic          keep;

	assign keep    = cnt_q < CW'(MAX_ITEMS);
	assign q_push  = push && !q_full;
	assign q_value = item.value;
	assign q_pos   = cnt_q[AW-1:0];
	assign q_count = keep ? cnt_q + CW'(1) : cnt_q;
	assign q_ctl   = '{last: item.last_item, keep: keep};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push) begin
			if (item.last_item) begin
				cnt_q <= '0;
			end else if (keep) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

@@ rtl/tsp_fifo.sv @@
module tsp_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = cnt_q == (PW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + PW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/tsp_back.sv @@
module tsp_back #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [tsp_pkg::TARGET_BITS-1:0]  target,
	input  logic                             q_empty,
	output logic                             q_pop,
	input  tsp_pkg::ctl_t                    q_ctl,
	input  logic [tsp_pkg::VALUE_BITS-1:0]   q_value,
	input  logic [$clog2(MAX_ITEMS)-1:0]     q_pos,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]   q_count,
	input  logic                             pop,
	output logic                             empty,
	output tsp_pkg::result_t                 result
);
	localparam int CW = $clog2(MAX_ITEMS+1);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int VB = tsp_pkg::VALUE_BITS;
	localparam int SW = (VB + 1 > tsp_pkg::TARGET_BITS) ? VB + 1 : tsp_pkg::TARGET_BITS;
	localparam int PB = tsp_pkg::POS_BITS;

	logic [VB-1:0]    mem_q [MAX_ITEMS];
	logic [VB-1:0]    rd_q;
	logic [VB-1:0]    vi_q;
	logic [AW-1:0]    rd_addr;
	logic             mem_wr;

	tsp_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    n_q, i_q, j_q, i_d, j_d;
	logic             hit_q, hit_d;
	logic             out_valid_q;
	tsp_pkg::result_t res_q;
	logic             load_res;
	logic             match;

	assign mem_wr = state_q == tsp_pkg::ST_LOAD && !q_empty && q_ctl.keep;
	assign q_pop  = state_q == tsp_pkg::ST_LOAD && !q_empty;
	assign match  = SW'(rd_q) + SW'(vi_q) == SW'(target);

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[q_pos] <= q_value;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		hit_d    = hit_q;
		load_res = 1'b0;
		rd_addr  = i_q[AW-1:0];
		case (state_q)
			tsp_pkg::ST_LOAD: begin
				if (!q_empty && q_ctl.last) begin
					i_d     = '0;
					hit_d   = 1'b0;
					state_d = tsp_pkg::ST_RDI;
				end
			end
			tsp_pkg::ST_RDI: begin
				if (i_q + CW'(1) >= n_q) begin
					state_d = tsp_pkg::ST_DONE;
				end else begin
					state_d = tsp_pkg::ST_GETI;
				end
			end
			tsp_pkg::ST_GETI: begin
				j_d     = i_q + CW'(1);
				state_d = tsp_pkg::ST_RDJ;
			end
			tsp_pkg::ST_RDJ: begin
				rd_addr = j_q[AW-1:0];
				state_d = tsp_pkg::ST_CMP;
			end
			tsp_pkg::ST_CMP: begin
				if (match) begin
					hit_d   = 1'b1;
					state_d = tsp_pkg::ST_DONE;
				end else if (j_q + CW'(1) >= n_q) begin
					i_d     = i_q + CW'(1);
					state_d = tsp_pkg::ST_RDI;
				end else begin
					j_d     = j_q + CW'(1);
					state_d = tsp_pkg::ST_RDJ;
				end
			end
			tsp_pkg::ST_DONE: begin
				if (!out_valid_q || pop) begin
					load_res = 1'b1;
					state_d  = tsp_pkg::ST_LOAD;
				end
			end
			default: state_d = tsp_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsp_pkg::ST_LOAD;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		if (q_pop && q_ctl.last) begin
			n_q <= q_count;
		end
		if (state_q == tsp_pkg::ST_GETI) begin
			vi_q <= rd_q;
		end
		if (load_res) begin
			res_q.found           <= hit_q;
			res_q.first_position  <= hit_q ? PB'(i_q + CW'(1)) : '0;
			res_q.second_position <= hit_q ? PB'(j_q + CW'(1)) : '0;
		end
	end

	assign empty  = !out_valid_q;
	assign result = res_q;

endmodule

@@ rtl/tsp_checker.sv @@
`include "two_sum_pair_finder_macros.svh"

module tsp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input tsp_pkg::result_t result
);

	// a waiting result holds until taken
	`TSP_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

	`TSP_ASSERT_NOW(a_miss_zero, clk, arst_n, !empty && !result.found, result.first_position == '0 && result.second_position == '0)

	`TSP_ASSERT_NOW(a_pair_order, clk, arst_n, !empty && result.found, result.first_position != '0 && result.first_position < result.second_position)

endmodule

bind two_sum_pair_finder tsp_checker u_tsp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

@@ tb/sv/tb.sv @@
module tb;

	localparam int CAP = 1024;
	localparam int VB  = tsp_pkg::VALUE_BITS;
	localparam int TW  = tsp_pkg::TARGET_BITS;
	localparam int PB  = tsp_pkg::POS_BITS;
	localparam int ADW = tsp_pkg::APB_DW;
	localparam int AAW = tsp_pkg::APB_AW;
	localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AAW-1:0] paddr;
	logic [ADW-1:0] pwdata;
	logic [ADW-1:0] prdata;
	logic pready;
	logic push, full, empty, pop;
	tsp_pkg::item_t item;
	tsp_pkg::result_t result;

	two_sum_pair_finder DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	// predictor state
	logic [TW-1:0] target_q;
	logic [VB-1:0] list_vals[CAP];
	int list_len;

	tsp_pkg::item_t pending_q[$];
	tsp_pkg::result_t answer_q[$];
	int errors;
	bit drive_idle, drain_idle, stall_rx, hold_tx;
	int hold_cycles;
	longint unsigned cycle_cnt;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// smallest i, then smallest j > i with list[i] + list[j] == target
	function automatic tsp_pkg::result_t find_pair();
		tsp_pkg::result_t r;
		logic [TW:0] s;
		r = '0;
		for (int i = 0; i < list_len; i++) begin
			for (int j = i + 1; j < list_len; j++) begin
				s = {2'b0, list_vals[i]} + {2'b0, list_vals[j]};
				if (s == {1'b0, target_q}) begin
					r.found = 1'b1;
					r.first_position = PB'(i + 1);
					r.second_position = PB'(j + 1);
					return r;
				end
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full) begin
				if (list_len < CAP) begin
					list_vals[list_len] = item.value;
					list_len++;
				end
				if (item.last_item) begin
					answer_q.insert(answer_q.size(), find_pair());
					list_len = 0;
				end
			end
			if (!push || !full) begin
				if (pending_q.size() > 0 && !hold_tx &&
				    !(drive_idle && $urandom_range(99) < 38)) begin
					push <= 1'b1;
					item <= pending_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		tsp_pkg::result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (pop && !empty) begin
				if (answer_q.size() == 0) begin
					$error("request result with nothing expected");
					errors++;
				end else begin
					want = answer_q.pop_front();
					if (result.found !== want.found) begin
						$error("found exp %0d got %0d", want.found, result.found);
						errors++;
					end
					if (result.first_position !== want.first_position) begin
						$error("first_position exp %0d got %0d",
						       want.first_position, result.first_position);
						errors++;
					end
					if (result.second_position !== want.second_position) begin
						$error("second_position exp %0d got %0d",
						       want.second_position, result.second_position);
						errors++;
					end
				end
			end
			if (stall_rx && hold_cycles < 3000) begin
				hold_cycles++;
				pop <= 1'b0;
			end else begin
				pop <= !(drain_idle && $urandom_range(99) < 38);
			end
		end
	end

	task automatic apb_write(input logic [TW-1:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= tsp_pkg::REG_TARGET; pwdata <= ADW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		target_q = v;
	endtask

	task automatic wait_quiet();
		while (pending_q.size() > 0 || push || answer_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_list(input int n, input logic [VB-1:0] lo,
	                        input logic [VB-1:0] hi);
		tsp_pkg::item_t it;
		for (int k = 0; k < n; k++) begin
			it.value = VB'($urandom_range(hi, lo));
			it.last_item = (k == n - 1);
			pending_q.insert(pending_q.size(), it);
		end
	endtask

	task automatic add_item(input logic [VB-1:0] v, input bit l);
		tsp_pkg::item_t it;
		it.value = v;
		it.last_item = l;
		pending_q.insert(pending_q.size(), it);
	endtask

	// list with a planted pair (summing to the target if it fits in VB bits), other values mostly up to the target
	task automatic add_planted(input int n);
		tsp_pkg::item_t it;
		int a, b;
		logic [VB-1:0] x;
		a = $urandom_range(n - 2);
		b = $urandom_range(n - 1, a + 1);
		x = VB'($urandom_range(32'(target_q > 33'hFFFF_FFFF ?
		                           32'hFFFF_FFFF : target_q[31:0]), 0));
		for (int k = 0; k < n; k++) begin
			if (k == a) it.value = x;
			else if (k == b) it.value = VB'(target_q - x);
			else if ($urandom_range(3) == 0) it.value = VB'($urandom());
			else it.value = VB'($urandom_range(32'(target_q[31:0]), 0));
			it.last_item = (k == n - 1);
			pending_q.insert(pending_q.size(), it);
		end
	endtask

	initial begin
		logic [TW-1:0] targets[6];
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		target_q = '0;
		drive_idle = 1'b0; drain_idle = 1'b0; stall_rx = 1'b0; hold_tx = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: target 0 and default behavior
		add_item(32'd0, 1'b1);               // single item, no pair
		add_item(32'd0, 1'b0); add_item(32'd0, 1'b1);
		wait_quiet();
		apb_write(33'd10);
		add_item(32'd5, 1'b0); add_item(32'd3, 1'b0); add_item(32'd5, 1'b1);  // self skip
		add_item(32'd5, 1'b0); add_item(32'd1, 1'b1);                         // no pair
		add_item(32'd20, 1'b0); add_item(32'd4, 1'b0); add_item(32'd6, 1'b0);
		add_item(32'd6, 1'b1);                                                // too big skipped
		wait_quiet();
		apb_write(33'h1_FFFF_FFFE);
		add_item(32'hFFFF_FFFF, 1'b0); add_item(32'hFFFF_FFFF, 1'b1);
		add_item(32'hFFFF_FFFF, 1'b0); add_item(32'h0, 1'b1);
		wait_quiet();
		apb_write(33'h1_FFFF_FFFF);
		add_item(32'hFFFF_FFFF, 1'b0); add_item(32'hFFFF_FFFF, 1'b1);
		add_item(32'hAAAA_AAAA, 1'b0); add_item(32'h5555_5555, 1'b1);
		wait_quiet();
		apb_write(33'hFFFF_FFFF);
		add_item(32'h5555_5555, 1'b0); add_item(32'hAAAA_AAAA, 1'b1);
		wait_quiet();

		// overfull list: drop items beyond capacity, search still runs
		apb_write(33'd7);
		add_list(CAP + 3, 32'd100, 32'd200);
		add_item(32'd3, 1'b0);
		add_item(32'd4, 1'b1);
		wait_quiet();

		// random phases over several targets
		targets[0] = 33'd0; targets[1] = 33'd1000; targets[2] = 33'd50;
		targets[3] = 33'h1_FFFF_FFFF; targets[4] = 33'h1_2345_6789; targets[5] = 33'd77;
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(targets[ph]);
			drive_idle = (ph != 1);
			drain_idle = (ph != 1);
			for (int l = 0; l < 3; l++) begin
				case ($urandom_range(3))
					0: add_list($urandom_range(8, 2), 32'd0, 32'd60);
					1: add_list($urandom_range(3, 1), 32'd0, 32'hFFFF_FFFF);
					default: add_planted($urandom_range(8, 2));
				endcase
			end
			if (ph == 2) begin
				// block fills while results are held back
				stall_rx = 1'b1;
				for (int l = 0; l < 10; l++) add_list(4, 32'd0, 32'd60);
				while (pending_q.size() > 0) @(posedge clk);
				wait (hold_cycles >= 3000);
				stall_rx = 1'b0;
			end
			if (ph == 4) begin
				// sender pauses until every answer is back
				while (pending_q.size() > 0 || push) @(posedge clk);
				hold_tx = 1'b1;
				while (answer_q.size() > 0) @(posedge clk);
				hold_tx = 1'b0;
			end
			wait_quiet();
		end

		while (pending_q.size() > 0 || push || answer_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_front.sv
rtl/tsp_fifo.sv
rtl/tsp_back.sv
rtl/two_sum_pair_finder.sv
rtl/tsp_checker.sv
tb/sv/tb.sv
